// ===== rtl/cow_pkg.sv =====
package cow_pkg;

  localparam int OBJECTS       = 64;
  localparam int PAYLOAD_BYTES = 48;

  localparam int CMD_W  = 3;
  localparam int ID_W   = 6;
  localparam int OFF_W  = 6;
  localparam int BYTE_W = 8;
  localparam int TAG_W  = 64;
  localparam int STS_W  = 3;

  localparam int CNT_W       = $clog2(OBJECTS + 1);
  localparam int BYTES_TOTAL = OBJECTS * PAYLOAD_BYTES;
  localparam int ADDR_W      = $clog2(BYTES_TOTAL);
  localparam int COPY_W      = $clog2(PAYLOAD_BYTES + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_INSTALL_TAG  = 3'd0,
    CMD_INSTALL_BYTE = 3'd1,
    CMD_SEAL         = 3'd2,
    CMD_READ         = 3'd3,
    CMD_WRITE        = 3'd4,
    CMD_DROP         = 3'd5
  } cow_cmd_t;

  typedef enum logic [STS_W-1:0] {
    ST_OK         = 3'd0,
    ST_SEALED     = 3'd1,
    ST_FULL       = 3'd2,
    ST_BAD_OFFSET = 3'd3,
    ST_UNKNOWN    = 3'd4
  } cow_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_COPY,
    S_RESP
  } cow_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load_in;
    logic exec;
    logic copy;
    logic load_out;
  } cow_ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic promote;
    logic copy_done;
    logic out_free;
  } cow_sts_t;

endpackage

// ===== rtl/cow_ifs.sv =====
interface cow_in_if;
  logic                        valid;
  logic                        ready;
  logic [cow_pkg::CMD_W-1:0]   cmd;
  logic [cow_pkg::ID_W-1:0]    object_id;
  logic [cow_pkg::OFF_W-1:0]   byte_offset;
  logic [cow_pkg::BYTE_W-1:0]  data_byte;
  logic [cow_pkg::TAG_W-1:0]   obj_tag;

  modport source (output valid, cmd, object_id, byte_offset, data_byte, obj_tag,
                  input ready);
  modport sink   (input valid, cmd, object_id, byte_offset, data_byte, obj_tag,
                  output ready);
endinterface

interface cow_out_if;
  logic                        valid;
  logic                        ready;
  logic [cow_pkg::STS_W-1:0]   status;
  logic [cow_pkg::ID_W-1:0]    assigned_id;
  logic [cow_pkg::TAG_W-1:0]   tag_out;
  logic [cow_pkg::BYTE_W-1:0]  byte_out;
  logic                        from_shadow;
  logic                        promoted_now;
  logic [cow_pkg::CNT_W-1:0]   promotion_total;
  logic [cow_pkg::CNT_W-1:0]   installed_total;

  modport source (output valid, status, assigned_id, tag_out, byte_out, from_shadow,
                  promoted_now, promotion_total, installed_total,
                  input ready);
  modport sink   (input valid, status, assigned_id, tag_out, byte_out, from_shadow,
                  promoted_now, promotion_total, installed_total,
                  output ready);
endinterface

// ===== rtl/cow_ctrl.sv =====
module cow_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cow_pkg::cow_sts_t sts,
  output cow_pkg::cow_ctl_t ctl
);

  cow_pkg::cow_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cow_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cow_pkg::S_IDLE: begin
        if (in_valid) state_nxt = cow_pkg::S_EXEC;
      end
      cow_pkg::S_EXEC: begin
        state_nxt = sts.promote ? cow_pkg::S_COPY : cow_pkg::S_RESP;
      end
      cow_pkg::S_COPY: begin
        if (sts.copy_done) state_nxt = cow_pkg::S_RESP;
      end
      cow_pkg::S_RESP: begin
        if (sts.out_free) state_nxt = in_valid ? cow_pkg::S_EXEC : cow_pkg::S_IDLE;
      end
      default: state_nxt = cow_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    ctl.exec     = 1'b0;
    ctl.copy     = 1'b0;
    ctl.load_out = 1'b0;
    unique case (state_r)
      cow_pkg::S_IDLE: in_ready = 1'b1;
      cow_pkg::S_EXEC: ctl.exec = 1'b1;
      cow_pkg::S_COPY: ctl.copy = 1'b1;
      cow_pkg::S_RESP: begin
        // result leaves and the next item can come in on the same edge
        ctl.load_out = sts.out_free;
        in_ready     = sts.out_free;
      end
      default: in_ready = 1'b0;
    endcase
    ctl.load_in = in_valid & in_ready;
  end

endmodule

// ===== rtl/cow_dpath.sv =====
module cow_dpath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cow_pkg::cow_ctl_t           ctl,
  output cow_pkg::cow_sts_t           sts,
  input  logic [cow_pkg::CMD_W-1:0]   in_cmd,
  input  logic [cow_pkg::ID_W-1:0]    in_object_id,
  input  logic [cow_pkg::OFF_W-1:0]   in_byte_offset,
  input  logic [cow_pkg::BYTE_W-1:0]  in_data_byte,
  input  logic [cow_pkg::TAG_W-1:0]   in_obj_tag,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [cow_pkg::STS_W-1:0]   out_status,
  output logic [cow_pkg::ID_W-1:0]    out_assigned_id,
  output logic [cow_pkg::TAG_W-1:0]   out_tag_out,
  output logic [cow_pkg::BYTE_W-1:0]  out_byte_out,
  output logic                        out_from_shadow,
  output logic                        out_promoted_now,
  output logic [cow_pkg::CNT_W-1:0]   out_promotion_total,
  output logic [cow_pkg::CNT_W-1:0]   out_installed_total
);

  localparam int ADDR_W = cow_pkg::ADDR_W;
  localparam int COPY_W = cow_pkg::COPY_W;

  // latched item
  logic [cow_pkg::CMD_W-1:0]  cmd_r;
  logic [cow_pkg::ID_W-1:0]   id_r;
  logic [cow_pkg::OFF_W-1:0]  off_r;
  logic [cow_pkg::BYTE_W-1:0] data_r;
  logic [cow_pkg::TAG_W-1:0]  tag_in_r;

  // architectural state
  logic [cow_pkg::CNT_W-1:0]  installed_cnt_r;
  logic [cow_pkg::CNT_W-1:0]  promo_cnt_r;
  logic                       sealed_r;
  logic [cow_pkg::OBJECTS-1:0] marks_r;

  logic [cow_pkg::TAG_W-1:0]  tag_mem    [cow_pkg::OBJECTS];
  logic [cow_pkg::BYTE_W-1:0] shared_mem [cow_pkg::BYTES_TOTAL];
  logic [cow_pkg::BYTE_W-1:0] shadow_mem [cow_pkg::BYTES_TOTAL];
  logic [cow_pkg::TAG_W-1:0]  tag_rd_r;
  logic [cow_pkg::BYTE_W-1:0] shared_rd_r;
  logic [cow_pkg::BYTE_W-1:0] shadow_rd_r;

  // per-item result bits, captured at execute
  logic [cow_pkg::STS_W-1:0]  res_status_r;
  logic [cow_pkg::ID_W-1:0]   res_assigned_r;
  logic                       res_read_r;
  logic                       res_shadow_r;
  logic                       res_promo_r;

  // copy engine
  logic [COPY_W-1:0]          copy_cnt_r;
  logic                       copy_wr_en_r;
  logic [COPY_W-1:0]          copy_wr_off_r;

  logic                       out_valid_r;

  // decode
  logic                       id_known;
  logic                       off_ok;
  logic                       full;
  logic [cow_pkg::ID_W-1:0]   last_id;
  logic [cow_pkg::ID_W-1:0]   sel_id;
  logic [ADDR_W-1:0]          base;
  logic [ADDR_W-1:0]          acc_addr;
  logic [ADDR_W-1:0]          copy_raddr;
  logic [ADDR_W-1:0]          copy_waddr;
  logic                       copy_rd;
  logic [ADDR_W-1:0]          shared_raddr;
  logic                       shared_ren;
  logic [cow_pkg::BYTE_W-1:0] copy_wdata;

  cow_pkg::cow_status_t       status_c;
  logic [cow_pkg::ID_W-1:0]   assigned_c;
  logic                       do_tag_wr;
  logic                       do_shared_wr;
  logic                       do_shadow_wr;
  logic                       do_seal;
  logic                       do_drop;
  logic                       read_ok;
  logic                       promote_c;

  always_comb begin
    id_known   = cow_pkg::CNT_W'(id_r) < installed_cnt_r;
    off_ok     = int'(off_r) < cow_pkg::PAYLOAD_BYTES;
    full       = installed_cnt_r == cow_pkg::CNT_W'(cow_pkg::OBJECTS);
    last_id    = cow_pkg::ID_W'(installed_cnt_r - cow_pkg::CNT_W'(1));
    sel_id     = (cmd_r == cow_pkg::CMD_INSTALL_BYTE) ? last_id : id_r;
    base       = ADDR_W'(sel_id) * ADDR_W'(cow_pkg::PAYLOAD_BYTES);
    acc_addr   = base + ADDR_W'(off_r);
    copy_raddr = base + ADDR_W'(copy_cnt_r);
    copy_waddr = base + ADDR_W'(copy_wr_off_r);
    copy_rd    = ctl.copy && (copy_cnt_r != COPY_W'(cow_pkg::PAYLOAD_BYTES));
    shared_raddr = ctl.copy ? copy_raddr : acc_addr;
    shared_ren   = copy_rd || (ctl.exec && off_ok);
    // the byte being written replaces its copied original
    copy_wdata = (int'(copy_wr_off_r) == int'(off_r)) ? data_r : shared_rd_r;
  end

  always_comb begin
    status_c     = cow_pkg::ST_OK;
    assigned_c   = '0;
    do_tag_wr    = 1'b0;
    do_shared_wr = 1'b0;
    do_shadow_wr = 1'b0;
    do_seal      = 1'b0;
    do_drop      = 1'b0;
    read_ok      = 1'b0;
    promote_c    = 1'b0;
    case (cmd_r)
      cow_pkg::CMD_INSTALL_TAG: begin
        if (sealed_r) status_c = cow_pkg::ST_SEALED;
        else if (full) status_c = cow_pkg::ST_FULL;
        else begin
          do_tag_wr  = 1'b1;
          assigned_c = installed_cnt_r[cow_pkg::ID_W-1:0];
        end
      end
      cow_pkg::CMD_INSTALL_BYTE: begin
        if (sealed_r) status_c = cow_pkg::ST_SEALED;
        else if (installed_cnt_r == '0) status_c = cow_pkg::ST_UNKNOWN;
        else if (!off_ok) status_c = cow_pkg::ST_BAD_OFFSET;
        else begin
          do_shared_wr = 1'b1;
          assigned_c   = last_id;
        end
      end
      cow_pkg::CMD_SEAL: do_seal = 1'b1;
      cow_pkg::CMD_READ: begin
        if (!id_known) status_c = cow_pkg::ST_UNKNOWN;
        else if (!off_ok) status_c = cow_pkg::ST_BAD_OFFSET;
        else read_ok = 1'b1;
      end
      cow_pkg::CMD_WRITE: begin
        if (!id_known) status_c = cow_pkg::ST_UNKNOWN;
        else if (!off_ok) status_c = cow_pkg::ST_BAD_OFFSET;
        else if (marks_r[id_r]) do_shadow_wr = 1'b1;
        else promote_c = 1'b1;
      end
      cow_pkg::CMD_DROP: do_drop = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      cmd_r    <= in_cmd;
      id_r     <= in_object_id;
      off_r    <= in_byte_offset;
      data_r   <= in_data_byte;
      tag_in_r <= in_obj_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      installed_cnt_r <= '0;
      promo_cnt_r     <= '0;
      sealed_r        <= 1'b0;
      marks_r         <= '0;
    end else if (ctl.exec) begin
      if (do_tag_wr) installed_cnt_r <= installed_cnt_r + cow_pkg::CNT_W'(1);
      if (do_seal) sealed_r <= 1'b1;
      if (do_drop) begin
        marks_r     <= '0;
        promo_cnt_r <= '0;
      end else if (promote_c) begin
        // marked now; nothing reads the shadow before the copy ends
        marks_r[id_r] <= 1'b1;
        promo_cnt_r   <= promo_cnt_r + cow_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      res_status_r   <= status_c;
      res_assigned_r <= assigned_c;
      res_read_r     <= read_ok;
      res_shadow_r   <= read_ok & marks_r[id_r];
      res_promo_r    <= promote_c;
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (ctl.exec && do_tag_wr) tag_mem[installed_cnt_r[cow_pkg::ID_W-1:0]] <= tag_in_r;
    if (ctl.exec) tag_rd_r <= tag_mem[id_r];
  end

  always_ff @(posedge clk) begin
    if (ctl.exec && do_shared_wr) shared_mem[acc_addr] <= data_r;
    if (shared_ren) shared_rd_r <= shared_mem[shared_raddr];
  end

  always_ff @(posedge clk) begin
    if (ctl.exec && do_shadow_wr) shadow_mem[acc_addr] <= data_r;
    else if (copy_wr_en_r) shadow_mem[copy_waddr] <= copy_wdata;
    if (ctl.exec && off_ok) shadow_rd_r <= shadow_mem[acc_addr];
  end

  // copy: read shared byte n while byte n-1 is written to the shadow
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      copy_cnt_r   <= '0;
      copy_wr_en_r <= 1'b0;
    end else if (ctl.exec) begin
      copy_cnt_r   <= '0;
      copy_wr_en_r <= 1'b0;
    end else begin
      copy_wr_en_r <= copy_rd;
      if (copy_rd) copy_cnt_r <= copy_cnt_r + COPY_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    copy_wr_off_r <= copy_cnt_r;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      out_status          <= res_status_r;
      out_assigned_id     <= res_assigned_r;
      out_tag_out         <= res_read_r ? tag_rd_r : '0;
      out_byte_out        <= !res_read_r ? '0 : (res_shadow_r ? shadow_rd_r : shared_rd_r);
      out_from_shadow     <= res_shadow_r;
      out_promoted_now    <= res_promo_r;
      out_promotion_total <= promo_cnt_r;
      out_installed_total <= installed_cnt_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign sts.promote   = promote_c;
  assign sts.copy_done = copy_cnt_r == COPY_W'(cow_pkg::PAYLOAD_BYTES);
  assign sts.out_free  = !out_valid_r || out_ready;

endmodule

// ===== rtl/copy_on_write_object_overlay.sv =====
// Channel   Dir  Handshake      Payload
// in_ch     in   valid/ready    cmd, object_id, byte_offset, data_byte, obj_tag
// out_ch    out  valid/ready    status, assigned_id, tag_out, byte_out, from_shadow,
//                               promoted_now, promotion_total, installed_total
//
// Each item is latched, then executed against the stores; the result is loaded
// into the output register in the cycle that also takes the next transfer.
// A write that promotes first copies the object's 48 bytes through the single read
// port of the shared byte store into its shadow, one a cycle, with registered reads.
// Reset clears the counters, seal flag and promotion marks; the tag and byte
// stores are not cleared. While out_ready is low a finished result holds and no
// new transfer is taken once the next result is ready.
module copy_on_write_object_overlay (
  input  logic     clk,
  input  logic     rst_n,
  cow_in_if.sink   in_ch,
  cow_out_if.source out_ch
);

  cow_pkg::cow_ctl_t ctl;
  cow_pkg::cow_sts_t sts;
  logic              in_ready;

  cow_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  cow_dpath u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .ctl                 (ctl),
    .sts                 (sts),
    .in_cmd              (in_ch.cmd),
    .in_object_id        (in_ch.object_id),
    .in_byte_offset      (in_ch.byte_offset),
    .in_data_byte        (in_ch.data_byte),
    .in_obj_tag          (in_ch.obj_tag),
    .out_ready           (out_ch.ready),
    .out_valid           (out_ch.valid),
    .out_status          (out_ch.status),
    .out_assigned_id     (out_ch.assigned_id),
    .out_tag_out         (out_ch.tag_out),
    .out_byte_out        (out_ch.byte_out),
    .out_from_shadow     (out_ch.from_shadow),
    .out_promoted_now    (out_ch.promoted_now),
    .out_promotion_total (out_ch.promotion_total),
    .out_installed_total (out_ch.installed_total)
  );

  assign in_ch.ready = in_ready;

endmodule

// ===== rtl/cow_checker.sv =====
module cow_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [cow_pkg::STS_W-1:0]  status,
  input logic [cow_pkg::TAG_W-1:0]  tag_out,
  input logic [cow_pkg::BYTE_W-1:0] byte_out,
  input logic                       from_shadow,
  input logic                       promoted_now,
  input logic [cow_pkg::CNT_W-1:0]  promotion_total,
  input logic [cow_pkg::CNT_W-1:0]  installed_total
);

  // a held result stays until transferred
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // one item at a time: a transfer in closes the input for the next cycle
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken during execute");

  // failed commands return no read data and no promotion
  a_err_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status != cow_pkg::ST_OK) |->
      tag_out == '0 && byte_out == '0 && !from_shadow && !promoted_now)
    else $error("payload on refused command");

  // counts stay within the object range; a promotion is counted
  a_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> installed_total <= cow_pkg::CNT_W'(cow_pkg::OBJECTS) &&
      promotion_total <= installed_total && (!promoted_now || promotion_total != '0))
    else $error("count out of range");

endmodule

bind copy_on_write_object_overlay cow_checker u_cow_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .status          (out_ch.status),
  .tag_out         (out_ch.tag_out),
  .byte_out        (out_ch.byte_out),
  .from_shadow     (out_ch.from_shadow),
  .promoted_now    (out_ch.promoted_now),
  .promotion_total (out_ch.promotion_total),
  .installed_total (out_ch.installed_total)
);
